>>> rtl/rnb_pkg.sv
// Shared types, constants and fixed-point helpers of the Newton root basin classifier.
`timescale 1ns / 1ps
`default_nettype none
package rnb_pkg;

   localparam int MAX_ROOTS = 64;
   localparam int FRAC_BITS = 24;
   localparam int DIV_STEPS = 31;
   localparam int DIV_W     = 96;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   localparam logic [2:0] CSR_REAL_ORIGIN = 3'd0;
   localparam logic [2:0] CSR_REAL_STEP   = 3'd1;
   localparam logic [2:0] CSR_IMAG_ORIGIN = 3'd2;
   localparam logic [2:0] CSR_IMAG_STEP   = 3'd3;
   localparam logic [2:0] CSR_ITER_COUNT  = 3'd4;

   localparam logic signed [31:0] RST_REAL_ORIGIN = -32'sd13421773;
   localparam logic signed [31:0] RST_REAL_STEP   = 32'sd10486;
   localparam logic signed [31:0] RST_IMAG_ORIGIN = -32'sd8388608;
   localparam logic signed [31:0] RST_IMAG_STEP   = 32'sd10486;
   localparam logic [7:0]         RST_ITER_COUNT  = 8'd60;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_ITER, S_RRD, S_RDIFF, S_SQA, S_SQB, S_ISSUE,
      S_WAIT, S_SUM, S_FRD, S_FDIFF, S_FCMP, S_DONE
   } state_type;

   typedef enum logic [1:0] {PH_ROOT, PH_STEP, PH_DIST} phase_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [30:0] nlow;
      logic [30:0] quo;
      logic        ovf;
   } div_lane_type;

   typedef struct packed {
      logic         valid;
      logic [63:0]  den;
      div_lane_type a;
      div_lane_type b;
   } div_cell_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : 32'(v);
   endfunction

endpackage
`default_nettype wire

>>> rtl/rnb_div_cell.sv
// One restoring-division cell: takes one quotient bit for two numerators.
`timescale 1ns / 1ps
`default_nettype none
module rnb_div_cell (
   input  wire                        clock,
   input  wire                        reset,
   input  wire rnb_pkg::div_cell_type cell_in,
   output rnb_pkg::div_cell_type      cell_out
);

   rnb_pkg::div_cell_type cell_ff;
   rnb_pkg::div_lane_type lane_a_in, lane_b_in;
   logic [64:0] rem2_a, rem2_b, diff_a, diff_b;

   always_comb begin
      rem2_a = {cell_in.a.rem, cell_in.a.nlow[30]};
      rem2_b = {cell_in.b.rem, cell_in.b.nlow[30]};
      diff_a = rem2_a - {1'b0, cell_in.den};
      diff_b = rem2_b - {1'b0, cell_in.den};
      lane_a_in.rem  = diff_a[64] ? rem2_a[63:0] : diff_a[63:0];
      lane_a_in.quo  = {cell_in.a.quo[29:0], ~diff_a[64]};
      lane_a_in.nlow = {cell_in.a.nlow[29:0], 1'b0};
      lane_a_in.ovf  = cell_in.a.ovf;
      lane_b_in.rem  = diff_b[64] ? rem2_b[63:0] : diff_b[63:0];
      lane_b_in.quo  = {cell_in.b.quo[29:0], ~diff_b[64]};
      lane_b_in.nlow = {cell_in.b.nlow[29:0], 1'b0};
      lane_b_in.ovf  = cell_in.b.ovf;
   end

   always_ff @(posedge clock) begin
      cell_ff.den <= cell_in.den;
      cell_ff.a   <= lane_a_in;
      cell_ff.b   <= lane_b_in;
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else begin
         cell_ff.valid <= cell_in.valid;
      end
   end

   assign cell_out = cell_ff;

endmodule
`default_nettype wire

>>> rtl/rnb_div.sv
// Pipelined divider: floor(num * 2^(2*FRAC_BITS) / den) capped at 2^31-1, two lanes.
`timescale 1ns / 1ps
`default_nettype none
module rnb_div (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   input  wire  [31:0] num_a,
   input  wire  [31:0] num_b,
   input  wire  [63:0] den,
   output logic        done,
   output logic [30:0] quo_a,
   output logic [30:0] quo_b
);

   localparam int NSH = 2 * rnb_pkg::FRAC_BITS;

   logic [rnb_pkg::DIV_W-1:0] n_a, n_b, d_ext;
   rnb_pkg::div_cell_type entry_in, entry_ff;
   rnb_pkg::div_cell_type chain [rnb_pkg::DIV_STEPS+1];

   always_comb begin
      n_a   = rnb_pkg::DIV_W'(num_a) << NSH;
      n_b   = rnb_pkg::DIV_W'(num_b) << NSH;
      d_ext = rnb_pkg::DIV_W'(den) << rnb_pkg::DIV_STEPS;
      entry_in.valid  = start;
      entry_in.den    = den;
      entry_in.a.rem  = n_a[rnb_pkg::DIV_STEPS +: 64];
      entry_in.a.nlow = n_a[rnb_pkg::DIV_STEPS-1:0];
      entry_in.a.quo  = '0;
      entry_in.a.ovf  = (n_a >= d_ext);
      entry_in.b.rem  = n_b[rnb_pkg::DIV_STEPS +: 64];
      entry_in.b.nlow = n_b[rnb_pkg::DIV_STEPS-1:0];
      entry_in.b.quo  = '0;
      entry_in.b.ovf  = (n_b >= d_ext);
   end

   always_ff @(posedge clock) begin
      entry_ff.den <= entry_in.den;
      entry_ff.a   <= entry_in.a;
      entry_ff.b   <= entry_in.b;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign chain[0] = entry_ff;

   for (genvar k = 0; k < rnb_pkg::DIV_STEPS; k++) begin : g_cell
      rnb_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[k]),
         .cell_out (chain[k+1])
      );
   end

   assign done  = chain[rnb_pkg::DIV_STEPS].valid;
   assign quo_a = chain[rnb_pkg::DIV_STEPS].a.ovf ? '1 : chain[rnb_pkg::DIV_STEPS].a.quo;
   assign quo_b = chain[rnb_pkg::DIV_STEPS].b.ovf ? '1 : chain[rnb_pkg::DIV_STEPS].b.quo;

endmodule
`default_nettype wire

>>> rtl/newton_root_basin_classifier.sv
// Newton root basin classifier top level: root table, iteration sequencer, output register.
// Load beat: written to the root table while it has room, no result. Classify beat: the time
// from accept to result beat grows with the stored root count and the iteration count and is
// set by the 32-stage divider pipeline that every complex reciprocal passes through. One item is in flight.
// Reset clears the sequencer, the root count, the result valid and the config registers;
// the root table is not cleared and is only read below the root count.
`timescale 1ns / 1ps
`default_nettype none
module newton_root_basin_classifier #(
   parameter int MAX_ROOTS = rnb_pkg::MAX_ROOTS
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire         req_opcode,
   input  wire  [31:0] req_root_real,
   input  wire  [31:0] req_root_imag,
   input  wire  [11:0] req_pixel_x,
   input  wire  [11:0] req_pixel_y,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [5:0]  rsp_root_index,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [31:0] csr_wdata
);

   localparam int IW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;
   localparam int CW = $clog2(MAX_ROOTS + 1);
   localparam int AW = 33 + IW;

   // configuration registers
   logic signed [31:0] real_origin_ff, real_step_ff, imag_origin_ff, imag_step_ff;
   logic [7:0]         iter_count_ff;

   // sequencer state
   rnb_pkg::state_type state_ff, state_in;
   rnb_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         iter_ff, iter_in;
   logic [CW-1:0]      idx_ff, idx_in, cnt_ff, cnt_in, best_ff, best_in;
   logic [11:0]        px_ff, px_in, py_ff, py_in;
   logic signed [31:0] xr_ff, xr_in, xi_ff, xi_in;
   logic signed [AW-1:0] acc_r_ff, acc_r_in, acc_i_ff, acc_i_in;
   logic [31:0]        mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic               neg_a_ff, neg_a_in, neg_b_ff, neg_b_in;
   logic [63:0]        sq_ff, sq_in, den_ff, den_in, best_d_ff, best_d_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [5:0]         rsp_idx_ff, rsp_idx_in;

   // root table
   logic [63:0]        root_mem [MAX_ROOTS];
   logic [63:0]        rd_data_ff;
   logic               mem_we;

   // datapath
   logic signed [31:0] root_r, root_i, dr, di, sr, si, rec_r, rec_i, qa_s, qb_s;
   logic signed [44:0] prod_r, prod_i;
   logic [31:0]        mul_op;
   logic [63:0]        sq_now;
   logic               div_start, div_done;
   logic [30:0]        quo_a, quo_b;

   rnb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num_a (mag_a_ff),
      .num_b (mag_b_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo_a (quo_a),
      .quo_b (quo_b)
   );

   // Configuration: always ready, unknown indexes drop.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         real_origin_ff <= rnb_pkg::RST_REAL_ORIGIN;
         real_step_ff   <= rnb_pkg::RST_REAL_STEP;
         imag_origin_ff <= rnb_pkg::RST_IMAG_ORIGIN;
         imag_step_ff   <= rnb_pkg::RST_IMAG_STEP;
         iter_count_ff  <= rnb_pkg::RST_ITER_COUNT;
      end else if (csr_valid) begin
         case (csr_index)
            rnb_pkg::CSR_REAL_ORIGIN: real_origin_ff <= $signed(csr_wdata);
            rnb_pkg::CSR_REAL_STEP:   real_step_ff   <= $signed(csr_wdata);
            rnb_pkg::CSR_IMAG_ORIGIN: imag_origin_ff <= $signed(csr_wdata);
            rnb_pkg::CSR_IMAG_STEP:   imag_step_ff   <= $signed(csr_wdata);
            rnb_pkg::CSR_ITER_COUNT:  iter_count_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Root table: one write port for loads, one registered read port at idx_ff.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         root_mem[cnt_ff[IW-1:0]] <= {req_root_real, req_root_imag};
      end
      rd_data_ff <= root_mem[idx_ff[IW-1:0]];
   end

   // Shared arithmetic
   always_comb begin
      root_r = $signed(rd_data_ff[63:32]);
      root_i = $signed(rd_data_ff[31:0]);
      dr     = rnb_pkg::sat32(64'(xr_ff) - 64'(root_r));
      di     = rnb_pkg::sat32(64'(xi_ff) - 64'(root_i));
      sr     = rnb_pkg::sat32(64'(acc_r_ff));
      si     = rnb_pkg::sat32(64'(acc_i_ff));
      prod_r = $signed({1'b0, px_ff}) * real_step_ff;
      prod_i = $signed({1'b0, py_ff}) * imag_step_ff;
      mul_op = (state_ff == rnb_pkg::S_SQA) ? mag_a_ff : mag_b_ff;
      sq_now = 64'(mul_op) * 64'(mul_op);
      qa_s   = $signed({1'b0, quo_a});
      qb_s   = $signed({1'b0, quo_b});
      // reciprocal of a + bi is (a - bi) / |.|^2
      rec_r  = neg_a_ff ? -qa_s : qa_s;
      rec_i  = neg_b_ff ? qb_s : -qb_s;
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      iter_in      = iter_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      best_in      = best_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      xr_in        = xr_ff;
      xi_in        = xi_ff;
      acc_r_in     = acc_r_ff;
      acc_i_in     = acc_i_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      neg_a_in     = neg_a_ff;
      neg_b_in     = neg_b_ff;
      sq_in        = sq_ff;
      den_in       = den_ff;
      best_d_in    = best_d_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      req_ready    = 1'b0;

      // drop the result beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         rnb_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_opcode == rnb_pkg::OP_CLASSIFY) begin
                  px_in    = req_pixel_x;
                  py_in    = req_pixel_y;
                  state_in = rnb_pkg::S_START;
               end else if (cnt_ff < CW'(MAX_ROOTS)) begin
                  mem_we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         rnb_pkg::S_START: begin
            xr_in    = rnb_pkg::sat32(64'(prod_r) + 64'(real_origin_ff));
            xi_in    = rnb_pkg::sat32(64'(prod_i) + 64'(imag_origin_ff));
            iter_in  = '0;
            state_in = rnb_pkg::S_ITER;
         end
         rnb_pkg::S_ITER: begin
            idx_in = '0;
            if (iter_ff == iter_count_ff) begin
               best_in   = '0;
               best_d_in = '0;
               state_in  = rnb_pkg::S_FRD;
            end else begin
               acc_r_in = '0;
               acc_i_in = '0;
               phase_in = rnb_pkg::PH_ROOT;
               state_in = rnb_pkg::S_RRD;
            end
         end
         rnb_pkg::S_RRD: begin
            state_in = (idx_ff == cnt_ff) ? rnb_pkg::S_SUM : rnb_pkg::S_RDIFF;
         end
         rnb_pkg::S_RDIFF: begin
            if (dr == 32'sd0 && di == 32'sd0) begin
               // point sits on a root: hold it, skip this step
               iter_in  = iter_ff + 1'b1;
               state_in = rnb_pkg::S_ITER;
            end else begin
               mag_a_in = rnb_pkg::mag32(dr);
               mag_b_in = rnb_pkg::mag32(di);
               neg_a_in = dr[31];
               neg_b_in = di[31];
               state_in = rnb_pkg::S_SQA;
            end
         end
         rnb_pkg::S_SQA: begin
            sq_in    = sq_now;
            state_in = rnb_pkg::S_SQB;
         end
         rnb_pkg::S_SQB: begin
            den_in   = sq_ff + sq_now;
            state_in = (phase_ff == rnb_pkg::PH_DIST) ? rnb_pkg::S_FCMP : rnb_pkg::S_ISSUE;
         end
         rnb_pkg::S_ISSUE: begin
            div_start = 1'b1;
            state_in  = rnb_pkg::S_WAIT;
         end
         rnb_pkg::S_WAIT: begin
            if (div_done) begin
               if (phase_ff == rnb_pkg::PH_ROOT) begin
                  acc_r_in = acc_r_ff + AW'(rec_r);
                  acc_i_in = acc_i_ff + AW'(rec_i);
                  idx_in   = idx_ff + 1'b1;
                  state_in = rnb_pkg::S_RRD;
               end else begin
                  xr_in    = rnb_pkg::sat32(64'(xr_ff) - 64'(rec_r));
                  xi_in    = rnb_pkg::sat32(64'(xi_ff) - 64'(rec_i));
                  iter_in  = iter_ff + 1'b1;
                  state_in = rnb_pkg::S_ITER;
               end
            end
         end
         rnb_pkg::S_SUM: begin
            if (sr == 32'sd0 && si == 32'sd0) begin
               // zero derivative: hold the point
               iter_in  = iter_ff + 1'b1;
               state_in = rnb_pkg::S_ITER;
            end else begin
               mag_a_in = rnb_pkg::mag32(sr);
               mag_b_in = rnb_pkg::mag32(si);
               neg_a_in = sr[31];
               neg_b_in = si[31];
               phase_in = rnb_pkg::PH_STEP;
               state_in = rnb_pkg::S_SQA;
            end
         end
         rnb_pkg::S_FRD: begin
            state_in = (idx_ff == cnt_ff) ? rnb_pkg::S_DONE : rnb_pkg::S_FDIFF;
         end
         rnb_pkg::S_FDIFF: begin
            mag_a_in = rnb_pkg::mag32(dr);
            mag_b_in = rnb_pkg::mag32(di);
            phase_in = rnb_pkg::PH_DIST;
            state_in = rnb_pkg::S_SQA;
         end
         rnb_pkg::S_FCMP: begin
            // strict compare keeps the lower index on a tie
            if (idx_ff == '0 || den_ff < best_d_ff) begin
               best_d_in = den_ff;
               best_in   = idx_ff;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = rnb_pkg::S_FRD;
         end
         rnb_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = 6'(best_ff);
               state_in     = rnb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = rnb_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rnb_pkg::S_IDLE;
         phase_ff     <= rnb_pkg::PH_ROOT;
         iter_ff      <= '0;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         iter_ff      <= iter_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff    <= best_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      xr_ff      <= xr_in;
      xi_ff      <= xi_in;
      acc_r_ff   <= acc_r_in;
      acc_i_ff   <= acc_i_in;
      mag_a_ff   <= mag_a_in;
      mag_b_ff   <= mag_b_in;
      neg_a_ff   <= neg_a_in;
      neg_b_ff   <= neg_b_in;
      sq_ff      <= sq_in;
      den_ff     <= den_in;
      best_d_ff  <= best_d_in;
      rsp_idx_ff <= rsp_idx_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root_index = rsp_idx_ff;

   // Checks
   a_div_only_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == rnb_pkg::S_WAIT)
      else $error("divider result outside wait state");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_ROOTS))
      else $error("root count above table depth");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != rnb_pkg::S_IDLE |-> idx_ff <= cnt_ff)
      else $error("root index past root count");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == rnb_pkg::S_DONE)
      else $error("result beat not issued from done state");

endmodule
`default_nettype wire
